>>> hdl/selection_sort_engine_assert.svh
// Assertion macros for the selection sort engine.
// Used inside modules that provide clk and rst_n; no other dependencies.
`ifndef SELECTION_SORT_ENGINE_ASSERT_SVH
`define SELECTION_SORT_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ssort_pkg.sv
// Shared constants and types for the selection sort engine.
// No dependencies; imported by the top level.
`default_nettype none

package ssort_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_END,
        ST_SWAP_END,
        ST_SWAP_BEST,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } ssort_state_t;

endpackage

`default_nettype wire

>>> hdl/ssort_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/selection_sort_engine.sv
// Selection sort engine: loads signed 32-bit elements into one RAM of DEPTH entries,
// sorts each set in place when its last element arrives, and streams it out
// smallest first. The input is never stalled while a set is loading. A set
// is sorted in passes: each pass reads the unsorted part once through the
// single read port of the element RAM (one entry per cycle, with registered
// read data) and swaps with two writes. Each result is read from the RAM and
// then loaded into the output register when the output is not stalled.
// Elements beyond DEPTH are dropped and flagged as overflowed on every result
// of that set. The input is stalled from the last beat of a set until its
// final result is loaded into the output register.
// Depends on ssort_pkg and ssort_ram.
`default_nettype none

`include "selection_sort_engine_assert.svh"

module selection_sort_engine
    import ssort_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     last,
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic signed [DATA_W-1:0]      value_res,
    output logic                          last_res,
    output logic                          overflowed
);

    ssort_state_t       state_reg;
    ssort_state_t       state_next;

    logic [CNT_W-1:0]   cnt_reg;
    logic               drop_reg;
    logic [IDX_W-1:0]   iss_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic [IDX_W-1:0]   end_reg;
    logic [IDX_W-1:0]   emit_k_reg;
    logic [DATA_W-1:0]  best_val_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [DATA_W-1:0]  end_val_reg;
    logic               res_valid_reg;
    logic [DATA_W-1:0]  value_res_reg;
    logic               last_res_reg;
    logic               overflowed_reg;

    logic               accept;
    logic               full;
    logic [CNT_W-1:0]   load_cnt;
    logic               out_free;
    logic               last_sel;
    logic               take;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    ssort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rd_en (mem_rd_en),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept   = item_valid && !item_stall;
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign load_cnt = full ? cnt_reg : cnt_reg + CNT_W'(1);
    assign out_free = !res_valid_reg || !res_stall;
    assign last_sel = ((CNT_W'(emit_k_reg) + CNT_W'(1)) == cnt_reg);
    // first read of a pass seeds the running maximum
    assign take     = (pidx_reg == '0) || ($signed(mem_rdata) > $signed(best_val_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && last)
                begin
                    state_next = (load_cnt > CNT_W'(1)) ? ST_SCAN : ST_EMIT_RD;
                end
            end
            ST_SCAN:
            begin
                if (iss_reg == end_reg)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_SWAP_END;
            end
            ST_SWAP_END:
            begin
                state_next = ST_SWAP_BEST;
            end
            ST_SWAP_BEST:
            begin
                state_next = (end_reg == IDX_W'(1)) ? ST_EMIT_RD : ST_SCAN;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = last_sel ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // memory and handshake controls
    always_comb
    begin
        item_stall = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg[IDX_W-1:0];
        mem_wdata  = value;
        mem_rd_en  = 1'b0;
        mem_raddr  = iss_reg;
        case (state_reg)
            ST_LOAD:
            begin
                item_stall = 1'b0;
                mem_we     = item_valid && !full;
            end
            ST_SCAN:
            begin
                mem_rd_en = 1'b1;
            end
            ST_SWAP_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = best_val_reg;
            end
            ST_SWAP_BEST:
            begin
                mem_we    = 1'b1;
                mem_waddr = best_idx_reg;
                mem_wdata = end_val_reg;
            end
            ST_EMIT_RD:
            begin
                mem_rd_en = 1'b1;
                mem_raddr = emit_k_reg;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            end_reg       <= '0;
            emit_k_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCAN);

            if (state_reg == ST_LOAD && accept)
            begin
                cnt_reg  <= load_cnt;
                drop_reg <= drop_reg | full;
                if (last)
                begin
                    end_reg    <= IDX_W'(load_cnt - CNT_W'(1));
                    iss_reg    <= '0;
                    emit_k_reg <= '0;
                end
            end

            if (state_reg == ST_SCAN)
            begin
                iss_reg <= iss_reg + IDX_W'(1);
            end

            // shrink the unsorted part after each swap
            if (state_reg == ST_SWAP_BEST)
            begin
                end_reg <= end_reg - IDX_W'(1);
                iss_reg <= '0;
            end

            if (state_reg == ST_EMIT_OUT && out_free)
            begin
                res_valid_reg <= 1'b1;
                emit_k_reg    <= emit_k_reg + IDX_W'(1);
                if (last_sel)
                begin
                    cnt_reg  <= '0;
                    drop_reg <= 1'b0;
                end
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pidx_reg <= iss_reg;

        if ((state_reg == ST_SCAN || state_reg == ST_SCAN_END) && pend_reg && take)
        begin
            best_val_reg <= mem_rdata;
            best_idx_reg <= pidx_reg;
        end

        // hold the entry at the end of the unsorted part for the swap
        if (state_reg == ST_SCAN_END)
        begin
            end_val_reg <= mem_rdata;
        end

        if (state_reg == ST_EMIT_OUT && out_free)
        begin
            value_res_reg  <= mem_rdata;
            last_res_reg   <= last_sel;
            overflowed_reg <= drop_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign value_res  = $signed(value_res_reg);
    assign last_res   = last_res_reg;
    assign overflowed = overflowed_reg;

    `SSE_ASSERT_SAME(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(DEPTH),
        "element count exceeds store depth")
    `SSE_ASSERT_SAME(a_scan_bounds, state_reg == ST_SCAN,
        (end_reg != '0) && (CNT_W'(end_reg) < cnt_reg),
        "scan window outside loaded set")
    `SSE_ASSERT_SAME(a_scan_end_data, state_reg == ST_SCAN_END,
        pend_reg && (pidx_reg == end_reg),
        "scan end without read data of last unsorted entry")
    `SSE_ASSERT_NEXT(a_emit_done, (state_reg == ST_EMIT_OUT) && out_free && last_sel,
        (state_reg == ST_LOAD) && (cnt_reg == '0) && !drop_reg && res_valid && last_res,
        "final result did not return the engine to load")

endmodule

`default_nettype wire

>>> bench/selection_sort_engine_tb.sv
// Testbench for selection_sort_engine: loads sets of signed elements, predicts
// the sorted output of each set, and checks every result beat as it leaves.
// Depends on ssort_pkg and the selection_sort_engine RTL.
`timescale 1ns / 100ps

module selection_sort_engine_tb;
    import ssort_pkg::*;

    localparam int RAND_ITEMS  = 185;
    localparam int IDLE_PCT    = 31;
    localparam int TAIL_CYCLES = 64;
    localparam int WATCHDOG_NS = 1_000_000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     fin;
        logic                     ovf;
    } sorted_beat_t;

    typedef struct {
        logic signed [DATA_W-1:0] val;
        logic                     fin;
        bit                       typed;
        logic signed [DATA_W-1:0] exp_val;
        logic                     exp_ovf;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n      = 1'b0;
    logic                     item_valid = 1'b0;
    logic                     item_stall;
    logic signed [DATA_W-1:0] value      = '0;
    logic                     last       = 1'b0;
    logic                     res_valid;
    logic                     res_stall  = 1'b0;
    logic signed [DATA_W-1:0] value_res;
    logic                     last_res;
    logic                     overflowed;

    logic                     quiet      = 1'b0;
    int                       mismatches = 0;

    // predictor state: the set being loaded
    logic signed [DATA_W-1:0] elem_store [DEPTH];
    int                       elem_count   = 0;
    logic                     elem_dropped = 1'b0;

    sorted_beat_t             pending_sorted [$];
    stim_row_t                dir_rows [$];

    selection_sort_engine i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .last       (last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .value_res  (value_res),
        .last_res   (last_res),
        .overflowed (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Store one element; on the end of a set, sort and queue its results.
    function automatic int stage_element(logic signed [DATA_W-1:0] v, logic fin);
        logic signed [DATA_W-1:0] work [DEPTH];
        logic signed [DATA_W-1:0] tmp;
        int                       n;
        int                       best;
        if (elem_count < DEPTH)
        begin
            elem_store[elem_count] = v;
            elem_count++;
        end
        else
        begin
            elem_dropped = 1'b1;
        end
        if (!fin)
            return 0;
        n = elem_count;
        work = elem_store;
        // move the largest of the unsorted front to its end (the end entry wins a tie, else the first)
        for (int top = n - 1; top >= 1; top--)
        begin
            best = top;
            for (int k = 0; k < top; k++)
                if (work[k] > work[best])
                    best = k;
            tmp = work[best];
            work[best] = work[top];
            work[top] = tmp;
        end
        for (int k = 0; k < n; k++)
            pending_sorted.push_back('{work[k], k == n - 1, elem_dropped});
        elem_count = 0;
        elem_dropped = 1'b0;
        return n;
    endfunction

    function automatic void add_row(logic signed [DATA_W-1:0] v, logic fin, bit typed = 0,
                                    logic signed [DATA_W-1:0] ev = '0, logic eo = 1'b0);
        dir_rows.push_back('{v, fin, typed, ev, eo});
    endfunction

    task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic fin);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last       <= fin;
        // hold the beat until it is taken
        do @(posedge clk); while (item_stall);
    endtask

    task automatic wait_sorted_drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_sorted.size() != 0);
    endtask

    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_sorted.size() == 0)
            begin
                $error("unexpected result beat: value_res %0d last_res %0b overflowed %0b",
                       value_res, last_res, overflowed);
                mismatches++;
            end
            else
            begin
                want = pending_sorted.pop_front();
                if (value_res !== want.val)
                begin
                    $error("value_res: expected %0d, actual %0d", want.val, value_res);
                    mismatches++;
                end
                if (last_res !== want.fin)
                begin
                    $error("last_res: expected %0b, actual %0b", want.fin, last_res);
                    mismatches++;
                end
                if (overflowed !== want.ovf)
                begin
                    $error("overflowed: expected %0b, actual %0b", want.ovf, overflowed);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t                row;
        logic signed [DATA_W-1:0] v;
        logic                     fin;
        int                       n_res;
        int                       set_len;
        int                       mode;
        int                       sent;
        int                       set_no;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element sets straight after reset: the element comes back alone
        add_row(VAL_MIN, 1'b1, 1, VAL_MIN, 1'b0);
        add_row(VAL_MAX, 1'b1, 1, VAL_MAX, 1'b0);
        // repeated maxima and both extremes in one set
        add_row(3, 1'b0);
        add_row(-1, 1'b0);
        add_row(3, 1'b0);
        add_row(VAL_MIN, 1'b0);
        add_row(VAL_MAX, 1'b0);
        add_row(VAL_MAX, 1'b1);
        // fill the store, then drop the closing element
        for (int k = 0; k < DEPTH; k++)
            add_row((k % 2) ? -(k * 12345) : k * 99991, 1'b0);
        add_row(-7, 1'b1);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_beat(row.val, row.fin);
            n_res = stage_element(row.val, row.fin);
            if (row.typed)
            begin
                repeat (n_res) void'(pending_sorted.pop_back());
                pending_sorted.push_back('{row.exp_val, 1'b1, row.exp_ovf});
            end
        end
        wait_sorted_drain();

        sent = 0;
        set_no = 0;
        while (sent < RAND_ITEMS)
        begin
            // run a stretch of sets with neither side idling
            quiet <= (set_no >= 6 && set_no < 12);
            if ($urandom_range(0, 9) == 0)
                set_len = $urandom_range(DEPTH + 1, DEPTH + 4);
            else
                set_len = $urandom_range(1, DEPTH);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < set_len; k++)
            begin
                case (mode)
                    0: v = $urandom;
                    1: v = $urandom_range(0, 7) - 4;
                    default:
                        case ($urandom_range(0, 3))
                            0: v = VAL_MIN;
                            1: v = VAL_MAX;
                            2: v = '0;
                            default: v = -1;
                        endcase
                endcase
                fin = (k == set_len - 1);
                send_beat(v, fin);
                n_res = stage_element(v, fin);
                sent++;
            end
            set_no++;
            if ($urandom_range(0, 5) == 0)
                wait_sorted_drain();
        end

        wait_sorted_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
